>>> hdl/sabc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Straight alpha blend correction package
// Shared constants for the blend correction unit.
// ----------------------------------------------------------------------------
package sabc_pkg;

  // fraction bits of the internal fixed point format
  localparam int unsigned SABC_FRAC_BITS = 16;

  // channels that carry colour (blue, green, red)
  localparam int unsigned SABC_NUM_COLOR = 3;

endpackage
`default_nettype wire

>>> hdl/straight_alpha_blend_correction_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Straight alpha blend correction unit
// Unpremultiplies the destination, blends it with the source by the selected
// equations and re-premultiplies the result, one pixel per beat; a zero source alpha passes the destination through.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle, set by the nine-stage multiplier chain
// (reciprocal divide, correction, blend, premultiply, byte rounding).
// busy stays low; the receiver cannot stall and every beat leaves in order.
// Reset clears all stage valid bits and selects the non-premultiplied equations.
// ----------------------------------------------------------------------------
module straight_alpha_blend_correction_unit #(
  parameter int unsigned FRAC_BITS = sabc_pkg::SABC_FRAC_BITS
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [7:0] src_b_i,
  input  wire logic [7:0] src_g_i,
  input  wire logic [7:0] src_r_i,
  input  wire logic [7:0] src_a_i,
  input  wire logic [7:0] dst_b_i,
  input  wire logic [7:0] dst_g_i,
  input  wire logic [7:0] dst_r_i,
  input  wire logic [7:0] dst_a_i,
  input  wire logic       row_end_i,
  input  wire logic       frame_end_i,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic       cfg_data_i,
  output logic            done_o,
  output logic [7:0]      out_b_o,
  output logic [7:0]      out_g_o,
  output logic [7:0]      out_r_o,
  output logic [7:0]      out_a_o,
  output logic            touched_o,
  output logic            row_end_out_o,
  output logic            frame_end_out_o
);

  localparam int unsigned NC   = sabc_pkg::SABC_NUM_COLOR;
  localparam int unsigned FXW  = FRAC_BITS + 1;
  localparam int unsigned NW   = FRAC_BITS + 8;
  localparam int unsigned KSH  = FRAC_BITS + 8;
  localparam int unsigned RW   = FRAC_BITS + 9;
  localparam int unsigned PW   = NW + RW;
  localparam int unsigned MW   = 2 * FXW;
  localparam int unsigned NSTG = 8;
  localparam int unsigned LAT  = NSTG + 1;

  localparam logic [FXW-1:0] ONE_FX  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FXW-1:0] HALF_FX = {2'b01, {(FRAC_BITS - 1){1'b0}}};
  localparam logic [MW+8:0]  HALF_SQ = (MW + 9)'(1) << (2 * FRAC_BITS - 1);

  typedef struct packed {
    logic       pass;
    logic       row_end;
    logic       frame_end;
    logic [7:0] dst_b;
    logic [7:0] dst_g;
    logic [7:0] dst_r;
    logic [7:0] dst_a;
  } side_t;

  // constant tables: byte to fixed point and rounded-up reciprocal of alpha
  logic [FXW-1:0] b2f_tbl [256];
  logic [RW-1:0]  rcp_tbl [256];

  for (genvar gi = 0; gi < 256; gi++) begin : g_tbl
    assign b2f_tbl[gi] = FXW'(((64'(gi) << FRAC_BITS) + 64'd127) / 64'd255);
    if (gi == 0) begin : g_zero
      assign rcp_tbl[gi] = '0;
    end else begin : g_rcp
      assign rcp_tbl[gi] = RW'(((64'd1 << KSH) + 64'(gi) - 64'd1) / 64'(gi));
    end
  end

  logic [7:0] src_c [NC];
  logic [7:0] dst_c [NC];

  assign src_c[0] = src_b_i;
  assign src_c[1] = src_g_i;
  assign src_c[2] = src_r_i;
  assign dst_c[0] = dst_b_i;
  assign dst_c[1] = dst_g_i;
  assign dst_c[2] = dst_r_i;

  logic           blend_q;
  logic           v_q    [NSTG];
  side_t          side_q [NSTG];
  logic           in_acc;
  side_t          side_d;

  // stage 1
  logic [FXW-1:0] sa1_q, inv1_q, da1_q;
  logic [FXW-1:0] sca1_q [NC];
  logic [NW-1:0]  n1_q   [NC];
  logic           sat1_q [NC];
  logic [RW-1:0]  rcp1_q;
  logic [7:0]     dab1_q;
  logic           dz1_q;
  // stage 2
  logic [PW-1:0]  p2_q   [NC];
  logic [MW-1:0]  ssq2_q, dinv2_q;
  logic [FXW-1:0] da2_q, inv2_q;
  logic [FXW-1:0] sca2_q [NC];
  logic [NW-1:0]  n2_q   [NC];
  logic           sat2_q [NC];
  logic [7:0]     dab2_q;
  logic           dz2_q;
  // stage 3
  logic [FXW-1:0] qe3_q  [NC];
  logic [FXW-1:0] aout3_q, inv3_q;
  logic [FXW-1:0] sca3_q [NC];
  logic [NW-1:0]  n3_q   [NC];
  logic           sat3_q [NC];
  logic [7:0]     dab3_q;
  logic           dz3_q;
  // stage 4
  logic [FXW-1:0] c4_q   [NC];
  logic [FXW-1:0] aout4_q, inv4_q;
  logic [FXW-1:0] sca4_q [NC];
  // stage 5
  logic [MW-1:0]  cm5_q  [NC];
  logic [FXW-1:0] c5_q   [NC];
  logic [FXW-1:0] aout5_q;
  logic [FXW-1:0] sca5_q [NC];
  // stage 6
  logic [FXW-1:0] cout6_q [NC];
  logic [FXW-1:0] aout6_q;
  // stage 7
  logic [MW-1:0]  pc7_q  [NC];
  logic [7:0]     oa7_q;
  // stage 8
  logic [MW+7:0]  t8_q   [NC];
  logic [7:0]     oa8_q;
  // output
  logic           done_q;
  logic [7:0]     ob_q [NC];
  logic [7:0]     oa_q;
  logic           touched_q, row_end_q, frame_end_q;

  // combinational helpers
  logic [MW:0]    sq_rnd, di_rnd;
  logic [FXW:0]   asum;
  logic [FXW-1:0] aout3_d;
  logic [FXW+7:0] chk   [NC];
  logic [MW:0]    cm_rnd [NC];
  logic [FXW:0]   csum  [NC];
  logic [FXW+8:0] oa_w;
  logic [MW+8:0]  fin   [NC];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign in_acc      = start && !busy;

  assign side_d = '{pass:      (src_a_i == 8'd0),
                    row_end:   row_end_i,
                    frame_end: frame_end_i,
                    dst_b:     dst_b_i,
                    dst_g:     dst_g_i,
                    dst_r:     dst_r_i,
                    dst_a:     dst_a_i};

  always_comb begin
    sq_rnd  = (MW + 1)'(ssq2_q) + (MW + 1)'(HALF_FX);
    di_rnd  = (MW + 1)'(dinv2_q) + (MW + 1)'(HALF_FX);
    asum    = (FXW + 1)'(sq_rnd[FRAC_BITS +: FXW])
            + (FXW + 1)'(blend_q ? da2_q : di_rnd[FRAC_BITS +: FXW]);
    aout3_d = (asum > (FXW + 1)'(ONE_FX)) ? ONE_FX : asum[FXW-1:0];
    oa_w    = (FXW + 9)'({aout6_q, 8'h00}) - (FXW + 9)'(aout6_q) + (FXW + 9)'(HALF_FX);
    for (int ch = 0; ch < NC; ch++) begin
      chk[ch]    = (FXW + 8)'(qe3_q[ch]) * (FXW + 8)'(dab3_q);
      cm_rnd[ch] = (MW + 1)'(cm5_q[ch]) + (MW + 1)'(HALF_FX);
      csum[ch]   = (FXW + 1)'(sca5_q[ch])
                 + (FXW + 1)'(blend_q ? c5_q[ch] : cm_rnd[ch][FRAC_BITS +: FXW]);
      fin[ch]    = (MW + 9)'(t8_q[ch]) + HALF_SQ;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_q <= 1'b0;
      done_q  <= 1'b0;
      for (int s = 0; s < NSTG; s++) begin
        v_q[s] <= 1'b0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        blend_q <= cfg_data_i;
      end
      v_q[0] <= in_acc;
      for (int s = 1; s < NSTG; s++) begin
        v_q[s] <= v_q[s-1];
      end
      done_q <= v_q[NSTG-1];
    end
  end

  always_ff @(posedge clk_i) begin
    // stage 1: table lookups and operand prep
    side_q[0] <= side_d;
    sa1_q     <= b2f_tbl[src_a_i];
    inv1_q    <= ONE_FX - b2f_tbl[src_a_i];
    da1_q     <= b2f_tbl[dst_a_i];
    rcp1_q    <= rcp_tbl[dst_a_i];
    dab1_q    <= dst_a_i;
    dz1_q     <= (dst_a_i == 8'd0);
    for (int ch = 0; ch < NC; ch++) begin
      sca1_q[ch] <= b2f_tbl[src_c[ch]];
      n1_q[ch]   <= NW'({dst_c[ch], {FRAC_BITS{1'b0}}}) + NW'(dst_a_i[7:1]);
      sat1_q[ch] <= (dst_c[ch] >= dst_a_i);
    end
    for (int s = 1; s < NSTG; s++) begin
      side_q[s] <= side_q[s-1];
    end

    // stage 2: reciprocal products and alpha products
    ssq2_q  <= MW'(sa1_q) * MW'(sa1_q);
    dinv2_q <= MW'(da1_q) * MW'(inv1_q);
    da2_q   <= da1_q;
    inv2_q  <= inv1_q;
    dab2_q  <= dab1_q;
    dz2_q   <= dz1_q;
    for (int ch = 0; ch < NC; ch++) begin
      p2_q[ch]   <= PW'(n1_q[ch]) * PW'(rcp1_q);
      sca2_q[ch] <= sca1_q[ch];
      n2_q[ch]   <= n1_q[ch];
      sat2_q[ch] <= sat1_q[ch];
    end

    // stage 3: quotient estimate and new alpha
    aout3_q <= aout3_d;
    inv3_q  <= inv2_q;
    dab3_q  <= dab2_q;
    dz3_q   <= dz2_q;
    for (int ch = 0; ch < NC; ch++) begin
      qe3_q[ch]  <= p2_q[ch][KSH +: FXW];
      sca3_q[ch] <= sca2_q[ch];
      n3_q[ch]   <= n2_q[ch];
      sat3_q[ch] <= sat2_q[ch];
    end

    // stage 4: correct quotient, straight destination colour
    aout4_q <= aout3_q;
    inv4_q  <= inv3_q;
    for (int ch = 0; ch < NC; ch++) begin
      priority if (dz3_q) begin
        c4_q[ch] <= '0;
      end else if (sat3_q[ch]) begin
        c4_q[ch] <= ONE_FX;
      end else if (chk[ch] > (FXW + 8)'(n3_q[ch])) begin
        c4_q[ch] <= qe3_q[ch] - FXW'(1);
      end else begin
        c4_q[ch] <= qe3_q[ch];
      end
      sca4_q[ch] <= sca3_q[ch];
    end

    // stage 5: scale destination colour
    aout5_q <= aout4_q;
    for (int ch = 0; ch < NC; ch++) begin
      cm5_q[ch]  <= MW'(c4_q[ch]) * MW'(inv4_q);
      c5_q[ch]   <= c4_q[ch];
      sca5_q[ch] <= sca4_q[ch];
    end

    // stage 6: new colour, saturated
    aout6_q <= aout5_q;
    for (int ch = 0; ch < NC; ch++) begin
      cout6_q[ch] <= (csum[ch] > (FXW + 1)'(ONE_FX)) ? ONE_FX : csum[ch][FXW-1:0];
    end

    // stage 7: premultiply, alpha byte
    oa7_q <= oa_w[FRAC_BITS +: 8];
    for (int ch = 0; ch < NC; ch++) begin
      pc7_q[ch] <= MW'(cout6_q[ch]) * MW'(aout6_q);
    end

    // stage 8: scale to byte range
    oa8_q <= oa7_q;
    for (int ch = 0; ch < NC; ch++) begin
      t8_q[ch] <= (MW + 8)'({pc7_q[ch], 8'h00}) - (MW + 8)'(pc7_q[ch]);
    end

    // output: round or pass the destination through
    touched_q   <= !side_q[NSTG-1].pass;
    row_end_q   <= side_q[NSTG-1].row_end;
    frame_end_q <= side_q[NSTG-1].frame_end;
    if (side_q[NSTG-1].pass) begin
      ob_q[0] <= side_q[NSTG-1].dst_b;
      ob_q[1] <= side_q[NSTG-1].dst_g;
      ob_q[2] <= side_q[NSTG-1].dst_r;
      oa_q    <= side_q[NSTG-1].dst_a;
    end else begin
      for (int ch = 0; ch < NC; ch++) begin
        ob_q[ch] <= fin[ch][2 * FRAC_BITS +: 8];
      end
      oa_q <= oa8_q;
    end
  end

  assign done_o          = done_q;
  assign out_b_o         = ob_q[0];
  assign out_g_o         = ob_q[1];
  assign out_r_o         = ob_q[2];
  assign out_a_o         = oa_q;
  assign touched_o       = touched_q;
  assign row_end_out_o   = row_end_q;
  assign frame_end_out_o = frame_end_q;

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> ##LAT done_o)
    else $error("accepted beat did not complete after the pipeline latency");

  a_no_phantom : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(in_acc, LAT))
    else $error("result beat without a matching accepted beat");

  a_touched : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (touched_o == $past(src_a_i != 8'd0, LAT)))
    else $error("touched flag does not match source alpha");

  a_pass : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !touched_o) |-> (out_a_o == $past(dst_a_i, LAT))
                            && (out_b_o == $past(dst_b_i, LAT)))
    else $error("untouched pixel was altered");

endmodule
`default_nettype wire
